// ----- design/m7sa_pkg.sv -----
// Package for the mode 7 scanline affine block: shared constants, widths,
// register indexes and the configuration struct. No dependencies.
`timescale 1ns / 1ps
package m7sa_pkg;

  localparam int unsigned Lines     = 160;
  localparam int unsigned HalfWidth = 120;
  localparam int unsigned DepthMul  = 1024;
  localparam int unsigned RecipNum  = 65536;
  localparam int unsigned RomDepth  = 256;

  localparam int unsigned LineW   = 8;
  localparam int unsigned HeightW = 16;
  localparam int unsigned PosW    = 24;
  localparam int unsigned TrigW   = 10;
  localparam int unsigned RecipW  = 17;
  localparam int unsigned HW      = 12;
  localparam int unsigned LamW    = 16;
  localparam int unsigned ScaleW  = 18;
  localparam int unsigned StepW   = 16;
  localparam int unsigned OffW    = 28;
  localparam int unsigned SumW    = 32;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [2:0] RegPosX   = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegPosZ   = 3'd2;
  localparam logic [2:0] RegCos    = 3'd3;
  localparam logic [2:0] RegSin    = 3'd4;

  typedef struct packed {
    logic signed [PosW-1:0]  pos_x;
    logic [HeightW-1:0]      height;
    logic signed [PosW-1:0]  pos_z;
    logic signed [TrigW-1:0] cos_v;
    logic signed [TrigW-1:0] sin_v;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

// ----- design/mode7_scanline_affine.sv -----
// Top level of the mode 7 scanline affine block: configuration registers,
// offset stage and result registers. Depends on m7sa_pkg, m7sa_recip_rom, m7sa_scale.
//
//  Channel   Signals                                   Direction
//  command   start, busy, scan_line_i                  in (busy out)
//  result    result_valid_o, step_a_o, step_c_o,       out
//            offset_x_o, offset_y_o
//  config    psel, penable, pwrite, paddr, pwdata,     in (prdata, pready out)
//            prdata, pready
//
// A line is taken in every cycle; busy stays low. Each result is registered after
// each step of its command beat in turn: reciprocal lookup, height product, cosine
// and sine products, offset sums. The receiver cannot stall, so nothing holds
// the pipeline. Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
module mode7_scanline_affine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [m7sa_pkg::LineW-1:0]          scan_line_i,
  output logic                                result_valid_o,
  output logic signed [m7sa_pkg::StepW-1:0]   step_a_o,
  output logic signed [m7sa_pkg::StepW-1:0]   step_c_o,
  output logic signed [m7sa_pkg::OffW-1:0]    offset_x_o,
  output logic signed [m7sa_pkg::OffW-1:0]    offset_y_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [m7sa_pkg::AddrW-1:0]          paddr,
  input  logic [m7sa_pkg::DataW-1:0]          pwdata,
  output logic [m7sa_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  m7sa_pkg::cfg_t                     cfg_q;
  m7sa_pkg::ctl_t                     rom_ctl, scale_ctl;
  logic [m7sa_pkg::RecipW-1:0]        recip;
  logic signed [m7sa_pkg::ScaleW-1:0] lcf, lsf;
  logic                               wr_en;
  logic [2:0]                         reg_idx;
  logic                               valid_q;
  logic [m7sa_pkg::StepW-1:0]         step_a_q, step_c_q;
  logic [m7sa_pkg::OffW-1:0]          offset_x_q, offset_y_q;
  logic [m7sa_pkg::SumW-1:0]          lcf_ext, lsf_ext, pos_x_ext, pos_z_ext;
  logic [m7sa_pkg::SumW-1:0]          sum_x, sum_y;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[m7sa_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x  <= '0;
      cfg_q.height <= '0;
      cfg_q.pos_z  <= '0;
      cfg_q.cos_v  <= m7sa_pkg::TrigW'(256);
      cfg_q.sin_v  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        m7sa_pkg::RegPosX:   cfg_q.pos_x  <= pwdata[m7sa_pkg::PosW-1:0];
        m7sa_pkg::RegHeight: cfg_q.height <= pwdata[m7sa_pkg::HeightW-1:0];
        m7sa_pkg::RegPosZ:   cfg_q.pos_z  <= pwdata[m7sa_pkg::PosW-1:0];
        m7sa_pkg::RegCos:    cfg_q.cos_v  <= pwdata[m7sa_pkg::TrigW-1:0];
        m7sa_pkg::RegSin:    cfg_q.sin_v  <= pwdata[m7sa_pkg::TrigW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      m7sa_pkg::RegPosX:   prdata = m7sa_pkg::DataW'(cfg_q.pos_x);
      m7sa_pkg::RegHeight: prdata = m7sa_pkg::DataW'(cfg_q.height);
      m7sa_pkg::RegPosZ:   prdata = m7sa_pkg::DataW'(cfg_q.pos_z);
      m7sa_pkg::RegCos:    prdata = m7sa_pkg::DataW'(cfg_q.cos_v);
      m7sa_pkg::RegSin:    prdata = m7sa_pkg::DataW'(cfg_q.sin_v);
      default:             prdata = '0;
    endcase
  end

  m7sa_recip_rom u_rom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .line_i     (scan_line_i),
    .ctl_o      (rom_ctl),
    .recip_o    (recip)
  );

  m7sa_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctl_i   (rom_ctl),
    .recip_i (recip),
    .ctl_o   (scale_ctl),
    .lcf_o   (lcf),
    .lsf_o   (lsf)
  );

  assign lcf_ext   = m7sa_pkg::SumW'(lcf);
  assign lsf_ext   = m7sa_pkg::SumW'(lsf);
  assign pos_x_ext = m7sa_pkg::SumW'(cfg_q.pos_x);
  assign pos_z_ext = m7sa_pkg::SumW'(cfg_q.pos_z);
  assign sum_x = pos_x_ext - lcf_ext * m7sa_pkg::SumW'(m7sa_pkg::HalfWidth)
               + lsf_ext * m7sa_pkg::SumW'(m7sa_pkg::DepthMul);
  assign sum_y = pos_z_ext - lsf_ext * m7sa_pkg::SumW'(m7sa_pkg::HalfWidth)
               - lcf_ext * m7sa_pkg::SumW'(m7sa_pkg::DepthMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= scale_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scale_ctl.zero) begin
      step_a_q   <= '0;
      step_c_q   <= '0;
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else begin
      step_a_q   <= m7sa_pkg::StepW'(lcf >>> 4);
      step_c_q   <= m7sa_pkg::StepW'(lsf >>> 4);
      offset_x_q <= sum_x[m7sa_pkg::SumW-1:4];
      offset_y_q <= sum_y[m7sa_pkg::SumW-1:4];
    end
  end

  assign result_valid_o = valid_q;
  assign step_a_o       = step_a_q;
  assign step_c_o       = step_c_q;
  assign offset_x_o     = offset_x_q;
  assign offset_y_o     = offset_y_q;

endmodule

// ----- design/m7sa_recip_rom.sv -----
// Reciprocal lookup stage: registers floor(65536/line) for lines 1 to 159, zero
// otherwise, and flags lines beyond the screen. Depends on m7sa_pkg.
`timescale 1ns / 1ps
module m7sa_recip_rom (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [m7sa_pkg::LineW-1:0]        line_i,
  output m7sa_pkg::ctl_t                    ctl_o,
  output logic [m7sa_pkg::RecipW-1:0]       recip_o
);

  logic [m7sa_pkg::RecipW-1:0] rom [m7sa_pkg::RomDepth];
  m7sa_pkg::ctl_t              ctl_q;
  logic [m7sa_pkg::RecipW-1:0] recip_q;

  for (genvar g = 0; g < m7sa_pkg::RomDepth; g++) begin : g_rom
    localparam int unsigned RecipVal =
      (g == 0 || g >= m7sa_pkg::Lines) ? 0 : m7sa_pkg::RecipNum / g;
    assign rom[g] = m7sa_pkg::RecipW'(RecipVal);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= in_valid_i;
      ctl_q.zero  <= ({1'b0, line_i} >= 9'(m7sa_pkg::Lines));
    end
  end

  always_ff @(posedge clk_i) begin
    recip_q <= rom[line_i];
  end

  assign ctl_o   = ctl_q;
  assign recip_o = recip_q;

endmodule

// ----- design/m7sa_scale.sv -----
// Scale stages: lam = (height/16 * recip) >> 12, then lam*cos >> 8 and
// lam*sin >> 8, each behind a register. Depends on m7sa_pkg.
`timescale 1ns / 1ps
module m7sa_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  m7sa_pkg::cfg_t                      cfg_i,
  input  m7sa_pkg::ctl_t                      ctl_i,
  input  logic [m7sa_pkg::RecipW-1:0]         recip_i,
  output m7sa_pkg::ctl_t                      ctl_o,
  output logic signed [m7sa_pkg::ScaleW-1:0]  lcf_o,
  output logic signed [m7sa_pkg::ScaleW-1:0]  lsf_o
);

  localparam int unsigned ProdW = m7sa_pkg::HW + m7sa_pkg::RecipW;
  localparam int unsigned TrigProdW = m7sa_pkg::LamW + 1 + m7sa_pkg::TrigW;

  m7sa_pkg::ctl_t                     ctl1_q, ctl2_q;
  logic [m7sa_pkg::LamW-1:0]          lam_q;
  logic [ProdW-1:0]                   lam_prod;
  logic [m7sa_pkg::HW-1:0]            h;
  logic signed [m7sa_pkg::LamW:0]     lam_ext;
  logic signed [TrigProdW-1:0]        cos_prod, sin_prod;
  logic signed [m7sa_pkg::ScaleW-1:0] lcf_q, lsf_q;

  assign h        = cfg_i.height[m7sa_pkg::HeightW-1:4];
  assign lam_prod = ProdW'(h) * ProdW'(recip_i);
  assign lam_ext  = $signed({1'b0, lam_q});
  assign cos_prod = TrigProdW'(lam_ext) * TrigProdW'(cfg_i.cos_v);
  assign sin_prod = TrigProdW'(lam_ext) * TrigProdW'(cfg_i.sin_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lam_q <= lam_prod[12 +: m7sa_pkg::LamW];
    lcf_q <= cos_prod[8 +: m7sa_pkg::ScaleW];
    lsf_q <= sin_prod[8 +: m7sa_pkg::ScaleW];
  end

  assign ctl_o = ctl2_q;
  assign lcf_o = lcf_q;
  assign lsf_o = lsf_q;

endmodule
